FILE: rtl/core/neighbor_table_next_hop_core_macros.svh
// ----------------------------------------------------------------------------
// Neighbor table core assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_NEXT_HOP_CORE_MACROS_SVH
`define NEIGHBOR_TABLE_NEXT_HOP_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define NTHN_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("neighbor table: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define NTHN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("neighbor table: next-cycle check failed");

`endif

FILE: rtl/core/nthn_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor table package
// Table geometry, register codes, item kinds and the channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package nthn_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int MAC_W       = 48;
    localparam int ENTRY_W     = MAC_W + ADDR_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_ADDRESS = CFG_IDX_W'(2);

    // Item kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] host_address;
        logic [MAC_W-1:0]  host_mac;
    } t_in_item;

    typedef struct packed {
        logic             stored;
        logic             address_known;
        logic             hop_found;
        logic [MAC_W-1:0] hop_mac;
    } t_out_item;

    // Result handoff from the scan engine to the output register
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_if;

endpackage

`default_nettype wire

FILE: rtl/core/nthn_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nthn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]                               i_wdata,
    input  wire logic                                           i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/nthn_cfg.sv
// ----------------------------------------------------------------------------
// Neighbor table configuration registers
// Holds own address, netmask and gateway; resolves an address to its next hop.
// ----------------------------------------------------------------------------
`default_nettype none

module nthn_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [nthn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [nthn_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire logic [nthn_pkg::ADDR_W-1:0]    i_address,
    output logic      [nthn_pkg::ADDR_W-1:0]    o_hop
);

    logic [nthn_pkg::ADDR_W-1:0] r_own;
    logic [nthn_pkg::ADDR_W-1:0] r_mask;
    logic [nthn_pkg::ADDR_W-1:0] r_gw;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;

    // Register write decode; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own  <= '0;
            r_mask <= '0;
            r_gw   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nthn_pkg::CFG_OWN_ADDRESS:     r_own  <= i_cfg_data;
                nthn_pkg::CFG_SUBNET_MASK:     r_mask <= i_cfg_data;
                nthn_pkg::CFG_GATEWAY_ADDRESS: r_gw   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Route off-subnet addresses through the gateway
    assign o_hop = ((i_address & r_mask) != (r_own & r_mask)) ? r_gw : i_address;

endmodule

`default_nettype wire

FILE: rtl/core/nthn_scan.sv
// ----------------------------------------------------------------------------
// Neighbor table scan engine
// Walks the table RAM one entry per cycle, then writes an added pair to the first free entry, if any.
// ----------------------------------------------------------------------------
`default_nettype none
`include "neighbor_table_next_hop_core_macros.svh"

module nthn_scan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire nthn_pkg::t_in_item          i_in,
    input  wire logic [nthn_pkg::ADDR_W-1:0] i_hop,
    output nthn_pkg::t_res_if                o_res,
    input  wire logic                        i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_scan_state;

    t_scan_state r_state, n_state;

    nthn_pkg::t_in_item              r_item, n_item;
    logic [nthn_pkg::ADDR_W-1:0]     r_hop, n_hop;
    logic [nthn_pkg::CNT_W-1:0]      r_issue_cnt, n_issue_cnt;
    logic                            r_dv;
    logic [nthn_pkg::IDX_W-1:0]      r_dv_idx;
    logic [nthn_pkg::TABLE_DEPTH-1:0] r_entry_vld;
    logic                            r_known, n_known;
    logic                            r_hop_found, n_hop_found;
    logic [nthn_pkg::MAC_W-1:0]      r_hop_mac, n_hop_mac;
    logic                            r_free_found, n_free_found;
    logic [nthn_pkg::IDX_W-1:0]      r_free_idx, n_free_idx;

    logic                            in_xfer;
    logic                            rd_issue;
    logic [nthn_pkg::IDX_W-1:0]      rd_idx;
    logic [nthn_pkg::ENTRY_W-1:0]    rd_data;
    logic [nthn_pkg::ENTRY_W-1:0]    entry;
    logic [nthn_pkg::MAC_W-1:0]      ent_mac;
    logic [nthn_pkg::ADDR_W-1:0]     ent_addr;
    logic                            res_take;
    logic                            ram_we;
    logic                            is_add;

    // Take one item at a time
    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Issue one read per cycle until every entry is requested
    assign rd_issue = (r_state == S_SCAN) &&
                      (r_issue_cnt != nthn_pkg::CNT_W'(nthn_pkg::TABLE_DEPTH));
    assign rd_idx   = r_issue_cnt[nthn_pkg::IDX_W-1:0];

    // Never-written entries read as zero
    assign entry    = r_entry_vld[r_dv_idx] ? rd_data : '0;
    assign ent_mac  = entry[nthn_pkg::ENTRY_W-1:nthn_pkg::ADDR_W];
    assign ent_addr = entry[nthn_pkg::ADDR_W-1:0];

    // Write back only once the scan is over, so reads never see a pending write
    assign is_add   = (r_item.kind == nthn_pkg::KIND_ADD);
    assign res_take = (r_state == S_FIN) && i_res_ready;
    assign ram_we   = res_take && is_add && r_free_found;

    nthn_ram #(
        .WIDTH (nthn_pkg::ENTRY_W),
        .DEPTH (nthn_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata ({r_item.host_mac, r_item.host_address}),
        .i_re    (rd_issue),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    // Sequencer and per-entry compare
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_hop        = r_hop;
        n_issue_cnt  = r_issue_cnt;
        n_known      = r_known;
        n_hop_found  = r_hop_found;
        n_hop_mac    = r_hop_mac;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state      = S_SCAN;
                    n_item       = i_in;
                    n_hop        = i_hop;
                    n_issue_cnt  = '0;
                    n_known      = 1'b0;
                    n_hop_found  = 1'b0;
                    n_hop_mac    = '0;
                    n_free_found = 1'b0;
                    n_free_idx   = '0;
                end
            end
            S_SCAN: begin
                if (rd_issue) begin
                    n_issue_cnt = r_issue_cnt + nthn_pkg::CNT_W'(1);
                end
                if (r_dv) begin
                    if (ent_addr == r_item.host_address) begin
                        n_known = 1'b1;
                    end
                    if (!r_hop_found && (ent_addr == r_hop)) begin
                        n_hop_found = 1'b1;
                        n_hop_mac   = ent_mac;
                    end
                    if (!r_free_found && (ent_mac == '0)) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_dv_idx;
                    end
                    if (r_dv_idx == nthn_pkg::LAST_IDX) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dv        <= 1'b0;
            r_entry_vld <= '0;
        end else begin
            r_state <= n_state;
            r_dv    <= rd_issue;
            if (ram_we) begin
                r_entry_vld[r_free_idx] <= 1'b1;
            end
        end
    end

    // Item and scan payload
    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_hop        <= n_hop;
        r_issue_cnt  <= n_issue_cnt;
        r_dv_idx     <= rd_idx;
        r_known      <= n_known;
        r_hop_found  <= n_hop_found;
        r_hop_mac    <= n_hop_mac;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
    end

    // Present the result; fields of the other kind stay zero
    always_comb begin
        o_res.valid              = (r_state == S_FIN);
        o_res.item.stored        = is_add && r_free_found;
        o_res.item.address_known = !is_add && r_known;
        o_res.item.hop_found     = !is_add && r_hop_found;
        o_res.item.hop_mac       = (!is_add && r_hop_found) ? r_hop_mac : '0;
    end

    `NTHN_ASSERT_SAME(a_we_after_scan, ram_we, (r_state == S_FIN) && !rd_issue)
    `NTHN_ASSERT_SAME(a_res_after_all_reads,
        o_res.valid, r_issue_cnt == nthn_pkg::CNT_W'(nthn_pkg::TABLE_DEPTH))
    `NTHN_ASSERT_NEXT(a_written_entry_valid, ram_we, r_entry_vld[$past(r_free_idx)])
    `NTHN_ASSERT_SAME(a_data_only_in_scan, r_dv, r_state == S_SCAN)

endmodule

`default_nettype wire

FILE: rtl/core/neighbor_table_next_hop_core.sv
// The block takes one item at a time: o_in_stall stays high from acceptance until
// its result is handed to the output register, as the table RAM's single read port
// scans every entry once per item.
// The output register lets the next item start while a result waits to be taken.
// Reset (synchronous, active low) clears the control registers and marks every entry empty
// at once; the block accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
// Neighbor table next-hop core
// Add IPv4/MAC pairs to a fixed table and resolve lookups to a next-hop MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_table_next_hop_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [nthn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [nthn_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire nthn_pkg::t_in_item             i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output nthn_pkg::t_out_item                 o_out
);

    logic [nthn_pkg::ADDR_W-1:0] hop;
    nthn_pkg::t_res_if           res;
    logic                        res_ready;
    logic                        r_out_valid;
    nthn_pkg::t_out_item         r_out;

    nthn_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_address   (i_in.host_address),
        .o_hop       (hop)
    );

    nthn_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_hop       (hop),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Output slot is free when empty or being drained this cycle
    assign res_ready = !r_out_valid || !i_out_stall;

    // Hold the result until the downstream transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Neighbor table next-hop core testbench
// Drives add and lookup items through the core and checks every reply against a
// behavioral table copy or a hand-written reply. A short hand-written table of
// items and register writes comes first, then randomized phases under different
// subnet settings. Random idle bursts on both channels stop in the final phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import nthn_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = TABLE_DEPTH + 8;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 200;

    // Index past the register list; the core ignores writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    // Addresses that lookups and adds revisit, so hits and duplicates are common
    localparam logic [ADDR_W-1:0] HOST_POOL [16] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0002,
        32'h0A00_0003, 32'h0A00_0005, 32'h0A00_00FE, 32'h0A01_0203,
        32'hC0A8_0101, 32'hC0A8_0164, 32'hC0A8_FF01, 32'h0808_0808,
        32'h7F00_0001, 32'h8000_0000, 32'h0000_0001, 32'h0A00_0006
    };

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             row;
        t_in_item              item;
        bit                    by_hand;
        t_out_item             reply;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [ADDR_W-1:0]     reg_data;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [ADDR_W-1:0]     i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out;

    // Behavioral copy of the table and its registers
    logic [MAC_W-1:0]  nbr_mac [TABLE_DEPTH] = '{default: '0};
    logic [ADDR_W-1:0] nbr_ip  [TABLE_DEPTH] = '{default: '0};
    logic [ADDR_W-1:0] own_ip     = '0;
    logic [ADDR_W-1:0] net_mask   = '0;
    logic [ADDR_W-1:0] gateway_ip = '0;

    t_out_item table_replies [$];
    t_row      directed_rows [$];
    bit        idle_on = 1'b1;
    int        fault_count = 0;
    int        quiet_cycles = 0;

    neighbor_table_next_hop_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one item to the table copy and return the reply it produces
    function automatic t_out_item resolve_next_hop(input t_in_item it);
        t_out_item         res;
        logic [ADDR_W-1:0] hop;
        res = '0;
        if (it.kind == KIND_ADD) begin
            // take the lowest entry with an all-zero MAC
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (nbr_mac[i] == '0) begin
                    nbr_mac[i] = it.host_mac;
                    nbr_ip[i]  = it.host_address;
                    res.stored = 1'b1;
                    break;
                end
            end
        end else begin
            // off-subnet addresses go through the gateway
            hop = it.host_address;
            if ((it.host_address & net_mask) != (own_ip & net_mask)) begin
                hop = gateway_ip;
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (nbr_ip[i] == it.host_address) begin
                    res.address_known = 1'b1;
                end
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (nbr_ip[i] == hop) begin
                    res.hop_found = 1'b1;
                    res.hop_mac   = nbr_mac[i];
                    break;
                end
            end
        end
        return res;
    endfunction

    function automatic t_row hand_row(input logic kind, input logic [ADDR_W-1:0] addr,
                                      input logic [MAC_W-1:0] mac, input t_out_item reply);
        t_row r;
        r = '{row: ROW_ITEM, default: '0};
        r.row = ROW_ITEM;
        r.item.kind = kind;
        r.item.host_address = addr;
        r.item.host_mac = mac;
        r.by_hand = 1'b1;
        r.reply = reply;
        return r;
    endfunction

    function automatic t_row model_row(input logic kind, input logic [ADDR_W-1:0] addr,
                                       input logic [MAC_W-1:0] mac);
        t_row r;
        r = hand_row(kind, addr, mac, '0);
        r.by_hand = 1'b0;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [ADDR_W-1:0] data);
        t_row r;
        r = '{row: ROW_REG, default: '0};
        r.row = ROW_REG;
        r.reg_index = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.kind = ($urandom_range(0, 3) == 0) ? KIND_ADD : KIND_LOOKUP;
        it.host_address = ($urandom_range(0, 3) == 0) ? $urandom()
                                                      : HOST_POOL[$urandom_range(0, 15)];
        it.host_mac = MAC_W'({$urandom(), $urandom()});
        // most adds carry a zero MAC so the table fills slowly and entries get reused
        if (it.kind == KIND_ADD && $urandom_range(0, 3) != 0) begin
            it.host_mac = '0;
        end
        return it;
    endfunction

    // Offer one item, hold it until the transfer, then record its reply
    task automatic send_item(input t_in_item it, input bit by_hand, input t_out_item hand_reply);
        t_out_item reply;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        reply = resolve_next_hop(it);
        table_replies.push_back(by_hand ? hand_reply : reply);
    endtask

    // Drain the core, then write one register
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] data);
        i_in_valid <= 1'b0;
        while (table_replies.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_OWN_ADDRESS:     own_ip = data;
            CFG_SUBNET_MASK:     net_mask = data;
            CFG_GATEWAY_ADDRESS: gateway_ip = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stall the reply channel in random bursts
    initial begin
        int run;
        forever begin
            i_out_stall <= idle_on && $urandom_range(0, 1) == 1;
            run = $urandom_range(1, 15);
            repeat (run) @(posedge i_clk);
        end
    end

    // Check each reply transfer and watch for a hang
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (table_replies.size() == 0) begin
                    $error("reply with none pending: stored=%0b known=%0b found=%0b mac=%h",
                           o_out.stored, o_out.address_known, o_out.hop_found, o_out.hop_mac);
                    fault_count++;
                end else begin
                    want = table_replies.pop_front();
                    if (o_out.stored !== want.stored) begin
                        $error("stored: expected %0b, actual %0b", want.stored, o_out.stored);
                        fault_count++;
                    end
                    if (o_out.address_known !== want.address_known) begin
                        $error("address_known: expected %0b, actual %0b",
                               want.address_known, o_out.address_known);
                        fault_count++;
                    end
                    if (o_out.hop_found !== want.hop_found) begin
                        $error("hop_found: expected %0b, actual %0b",
                               want.hop_found, o_out.hop_found);
                        fault_count++;
                    end
                    if (o_out.hop_mac !== want.hop_mac) begin
                        $error("hop_mac: expected %h, actual %h", want.hop_mac, o_out.hop_mac);
                        fault_count++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL neighbor_table_next_hop_core");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        logic [ADDR_W-1:0] own;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gw;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;

        // After reset every entry is free and holds address 0; mask 0 keeps all on-subnet
        directed_rows.push_back(hand_row(KIND_LOOKUP, 32'h0, 48'h0, '{1'b0, 1'b1, 1'b1, 48'h0}));
        directed_rows.push_back(hand_row(KIND_LOOKUP, '1, '1, '{1'b0, 1'b0, 1'b0, 48'h0}));
        directed_rows.push_back(hand_row(KIND_ADD, '1, '1, '{1'b1, 1'b0, 1'b0, 48'h0}));
        directed_rows.push_back(hand_row(KIND_LOOKUP, '1, 48'h0, '{1'b0, 1'b1, 1'b1, '1}));
        // zero-MAC add lands but leaves the entry free for the next add
        directed_rows.push_back(hand_row(KIND_ADD, 32'h0A00_0005, 48'h0,
                                         '{1'b1, 1'b0, 1'b0, 48'h0}));
        directed_rows.push_back(hand_row(KIND_LOOKUP, 32'h0A00_0005, 48'h0,
                                         '{1'b0, 1'b1, 1'b1, 48'h0}));
        directed_rows.push_back(hand_row(KIND_ADD, 32'h0A00_0006, 48'h1,
                                         '{1'b1, 1'b0, 1'b0, 48'h0}));
        directed_rows.push_back(hand_row(KIND_LOOKUP, 32'h0A00_0005, 48'h0,
                                         '{1'b0, 1'b0, 1'b0, 48'h0}));
        directed_rows.push_back(model_row(KIND_ADD, 32'h0A00_0001, 48'h02AA_BBCC_DDEE));
        directed_rows.push_back(model_row(KIND_ADD, 32'h5555_5555, 48'hAAAA_AAAA_AAAA));
        directed_rows.push_back(model_row(KIND_ADD, 32'hAAAA_AAAA, 48'h5555_5555_5555));
        // on a /24 subnet, off-subnet lookups resolve through the gateway
        directed_rows.push_back(reg_row(CFG_OWN_ADDRESS, 32'h0A00_0001));
        directed_rows.push_back(reg_row(CFG_SUBNET_MASK, 32'hFFFF_FF00));
        directed_rows.push_back(reg_row(CFG_GATEWAY_ADDRESS, 32'h0A00_0006));
        directed_rows.push_back(model_row(KIND_LOOKUP, 32'h0A00_0001, 48'h0));
        directed_rows.push_back(model_row(KIND_LOOKUP, 32'h0808_0808, 48'h0));
        directed_rows.push_back(model_row(KIND_LOOKUP, 32'h5555_5555, 48'hAAAA_AAAA_AAAA));
        // gateway missing from the table
        directed_rows.push_back(reg_row(CFG_GATEWAY_ADDRESS, 32'h0102_0304));
        directed_rows.push_back(hand_row(KIND_LOOKUP, 32'h0808_0808, 48'h0,
                                         '{1'b0, 1'b0, 1'b0, 48'h0}));
        directed_rows.push_back(reg_row(CFG_UNUSED, '1));
        directed_rows.push_back(reg_row(CFG_SUBNET_MASK, '1));
        directed_rows.push_back(reg_row(CFG_OWN_ADDRESS, '1));
        directed_rows.push_back(model_row(KIND_LOOKUP, '1, 48'h0));
        directed_rows.push_back(model_row(KIND_LOOKUP, 32'h0A00_0001, 48'h0));
        // gateway 0 matches the first free entry
        directed_rows.push_back(reg_row(CFG_GATEWAY_ADDRESS, 32'h0));
        directed_rows.push_back(model_row(KIND_LOOKUP, 32'h1234_5678, 48'h0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed rows
        foreach (directed_rows[r]) begin
            if (directed_rows[r].row == ROW_REG) begin
                write_register(directed_rows[r].reg_index, directed_rows[r].reg_data);
            end else begin
                send_item(directed_rows[r].item, directed_rows[r].by_hand,
                          directed_rows[r].reply);
            end
        end

        // Random phases, each under its own subnet setting; the last runs without idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    own = 32'h0A00_0001; mask = 32'hFFFF_FF00; gw = 32'h0A00_00FE;
                end
                1: begin
                    own = 32'hC0A8_0164; mask = 32'hFFFF_0000; gw = 32'h0A00_0001;
                end
                2: begin
                    own = '0; mask = '0; gw = '0;
                end
                3: begin
                    own  = HOST_POOL[$urandom_range(0, 15)] ^ ADDR_W'($urandom_range(0, 255));
                    mask = '1 << $urandom_range(0, 32);
                    gw   = HOST_POOL[$urandom_range(0, 15)];
                end
                default: begin
                    own = HOST_POOL[$urandom_range(0, 15)]; mask = '1; gw = '1;
                end
            endcase
            idle_on = (phase != RANDOM_PHASES - 1);
            write_register(CFG_OWN_ADDRESS, own);
            write_register(CFG_SUBNET_MASK, mask);
            write_register(CFG_GATEWAY_ADDRESS, gw);
            if (phase == 3) begin
                write_register(CFG_UNUSED, $urandom());
            end
            repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
        end

        // Drain outstanding replies, then allow the pipeline to settle
        i_in_valid <= 1'b0;
        while (table_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("PASS neighbor_table_next_hop_core");
        end else begin
            $display("FAIL neighbor_table_next_hop_core");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: neighbor_table_next_hop_core.f
+incdir+rtl/core
rtl/core/nthn_pkg.sv
rtl/core/nthn_ram.sv
rtl/core/nthn_cfg.sv
rtl/core/nthn_scan.sv
rtl/core/neighbor_table_next_hop_core.sv
verif/testbench.sv
